// File: hw/rtl/binary_heap_priority_queue_macros.svh
// Assertion macros for the binary heap priority queue.
// Used by the port checker only; no dependencies.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define BHPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BHPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/bhpq_pkg.sv
// Package for the binary heap priority queue: sizes, codes and FSM states.
// No dependencies.
`default_nettype none

package bhpq_pkg;

	localparam int BHPQ_CAPACITY      = 64;
	localparam int BHPQ_KEY_WIDTH     = 32;
	localparam int BHPQ_PAYLOAD_WIDTH = 32;

	localparam int KEY_PORT_W     = 32;
	localparam int PAYLOAD_PORT_W = 32;
	localparam int COUNT_PORT_W   = 7;
	localparam int S_TDATA_W      = 64;
	localparam int S_TUSER_W      = 2;
	localparam int M_TDATA_W      = 136;
	localparam int M_TUSER_W      = 3;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef enum logic [0:0] {
		REG_LARGEST_FIRST = 1'b0
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_LAST_RD,
		ST_LAST_GET,
		ST_DN_RD,
		ST_DN_CMP,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// File: hw/rtl/bhpq_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module bhpq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output      logic [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output      logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// File: hw/rtl/binary_heap_priority_queue.sv
// Binary heap priority queue top level: control FSM, root cache, APB register.
// Depends on bhpq_pkg and bhpq_ram.
//
// channel   dir  tdata fields (low first)                        tuser (low first)
// s_*       in   key, payload                                    kind
// m_*       out  popped_key, popped_payload, entry_count,        status, top_valid
//                top_key, top_payload
// apb       in   largest_first at byte address 0
//
// Accept to m_tvalid: a push runs UP_RD and UP_CMP per level climbed, and only UP_RD
// at the root; a pop runs LAST_RD, LAST_GET, then DN_RD and DN_CMP per level; clear,
// ignored kinds, error cases and pop of the last entry go straight to DONE. Each level
// is one read and one compare/write of the RAM. s_tready rises with m_tvalid, so a new
// item is taken while a result waits in the output register; a stalled output holds the
// FSM in DONE. Reset empties the heap; the RAM contents are left as they are.
`default_nettype none

module binary_heap_priority_queue
	import bhpq_pkg::*;
#(
	parameter int CAPACITY      = BHPQ_CAPACITY,
	parameter int KEY_WIDTH     = BHPQ_KEY_WIDTH,
	parameter int PAYLOAD_WIDTH = BHPQ_PAYLOAD_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // key, payload
	input  wire logic [S_TUSER_W-1:0]  s_tuser,   // kind
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [M_TDATA_W-1:0]  m_tdata,   // popped_key, popped_payload,
	                                              // entry_count, top_key, top_payload, pad
	output      logic [M_TUSER_W-1:0]  m_tuser,   // status, top_valid
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output      logic [APB_DATA_W-1:0] prdata,
	output      logic                  pready
);

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CH_W   = ADDR_W + 2;
	localparam int ENT_W  = KEY_WIDTH + PAYLOAD_WIDTH;

	state_t state_q, state_d;

	logic [CNT_W-1:0]         cnt_q;
	logic [ADDR_W-1:0]        pos_q;
	logic [ENT_W-1:0]         ent_q;
	logic [ENT_W-1:0]         top_q;
	logic [KEY_WIDTH-1:0]     pop_key_q;
	logic [PAYLOAD_WIDTH-1:0] pop_pay_q;
	status_t                  status_q;
	logic                     largest_first_q;

	logic                     we;
	logic [ADDR_W-1:0]        waddr;
	logic [ENT_W-1:0]         wdata;
	logic [ADDR_W-1:0]        raddr_a, raddr_b;
	logic [ENT_W-1:0]         rdata_a, rdata_b;

	logic [ADDR_W-1:0]        pos_m1, parent;
	logic [CH_W-1:0]          left_w, right_w, cnt_w;
	logic                     left_ok, right_ok, sel_l, sel_r;
	logic [KEY_WIDTH-1:0]     ent_key, l_key, r_key, best_key, par_key;
	logic                     up_move;
	logic                     out_free, full, cnt_is_one, dn_stop;
	kind_t                    kind;
	logic [ENT_W-1:0]         new_ent;

	function automatic logic goes_before(input logic lf, input logic [KEY_WIDTH-1:0] a,
			input logic [KEY_WIDTH-1:0] b);
		goes_before = lf ? (a > b) : (a < b);
	endfunction

	bhpq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	assign kind     = kind_t'(s_tuser);
	assign new_ent  = {s_tdata[KEY_WIDTH-1:0], s_tdata[KEY_PORT_W +: PAYLOAD_WIDTH]};
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;
	assign full     = (cnt_q == CNT_W'(CAPACITY));
	assign cnt_is_one = (cnt_q == CNT_W'(1));

	assign pos_m1  = pos_q - ADDR_W'(1);
	assign parent  = ADDR_W'(pos_m1 >> 1);
	assign left_w  = {1'b0, pos_q, 1'b1};
	assign right_w = left_w + CH_W'(1);
	assign cnt_w   = CH_W'(cnt_q);
	assign left_ok  = left_w < cnt_w;
	assign right_ok = right_w < cnt_w;

	assign ent_key  = ent_q[ENT_W-1 -: KEY_WIDTH];
	assign l_key    = rdata_a[ENT_W-1 -: KEY_WIDTH];
	assign r_key    = rdata_b[ENT_W-1 -: KEY_WIDTH];
	assign par_key  = rdata_a[ENT_W-1 -: KEY_WIDTH];
	assign sel_l    = left_ok && goes_before(largest_first_q, l_key, ent_key);
	assign best_key = sel_l ? l_key : ent_key;
	assign sel_r    = right_ok && goes_before(largest_first_q, r_key, best_key);
	assign dn_stop  = !sel_l && !sel_r;
	assign up_move  = goes_before(largest_first_q, ent_key, par_key);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (kind)
						KIND_PUSH: state_d = full ? ST_DONE : ST_UP_RD;
						KIND_POP: begin
							if (cnt_q == '0 || cnt_is_one) begin
								state_d = ST_DONE;
							end else begin
								state_d = ST_LAST_RD;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_UP_RD:    state_d = (pos_q == '0) ? ST_DONE : ST_UP_CMP;
			ST_UP_CMP:   state_d = up_move ? ST_UP_RD : ST_DONE;
			ST_LAST_RD:  state_d = ST_LAST_GET;
			ST_LAST_GET: state_d = ST_DN_RD;
			ST_DN_RD:    state_d = ST_DN_CMP;
			ST_DN_CMP:   state_d = dn_stop ? ST_DONE : ST_DN_RD;
			ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = ent_q;
		raddr_a = left_w[ADDR_W-1:0];
		raddr_b = right_w[ADDR_W-1:0];
		case (state_q)
			ST_UP_RD: begin
				we      = (pos_q == '0);
				raddr_a = parent;
			end
			ST_UP_CMP: begin
				we    = 1'b1;
				wdata = up_move ? rdata_a : ent_q;
			end
			ST_LAST_RD: begin
				raddr_a = cnt_q[ADDR_W-1:0];
			end
			ST_DN_CMP: begin
				we    = 1'b1;
				wdata = sel_r ? rdata_b : (sel_l ? rdata_a : ent_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			m_tvalid        <= 1'b0;
			largest_first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && pready &&
					reg_idx_t'(paddr[2]) == REG_LARGEST_FIRST) begin
				largest_first_q <= pwdata[0];
			end
			if (state_q == ST_IDLE && s_tvalid) begin
				case (kind)
					KIND_PUSH: if (!full) cnt_q <= cnt_q + CNT_W'(1);
					KIND_POP:  if (cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
					KIND_CLEAR: cnt_q <= '0;
					default: cnt_q <= cnt_q;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	logic [KEY_WIDTH+KEY_PORT_W-1:0]         pk_ext, tk_ext;
	logic [PAYLOAD_WIDTH+PAYLOAD_PORT_W-1:0] pp_ext, tp_ext;
	logic [CNT_W+COUNT_PORT_W-1:0]           cnt_ext;
	logic                                    top_valid;

	assign top_valid = (cnt_q != '0);
	assign pk_ext  = {{KEY_PORT_W{1'b0}}, pop_key_q};
	assign pp_ext  = {{PAYLOAD_PORT_W{1'b0}}, pop_pay_q};
	assign tk_ext  = top_valid ? {{KEY_PORT_W{1'b0}}, top_q[ENT_W-1 -: KEY_WIDTH]} : '0;
	assign tp_ext  = top_valid ? {{PAYLOAD_PORT_W{1'b0}}, top_q[PAYLOAD_WIDTH-1:0]} : '0;
	assign cnt_ext = {{COUNT_PORT_W{1'b0}}, cnt_q};

	always_ff @(posedge clk) begin
		if (we && waddr == '0) begin
			top_q <= wdata;
		end
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (kind)
						KIND_PUSH: begin
							status_q  <= full ? STATUS_FULL : STATUS_OK;
							pop_key_q <= '0;
							pop_pay_q <= '0;
							ent_q     <= new_ent;
							pos_q     <= cnt_q[ADDR_W-1:0];
						end
						KIND_POP: begin
							pos_q <= '0;
							if (cnt_q == '0) begin
								status_q  <= STATUS_EMPTY;
								pop_key_q <= '0;
								pop_pay_q <= '0;
							end else begin
								status_q  <= STATUS_OK;
								pop_key_q <= top_q[ENT_W-1 -: KEY_WIDTH];
								pop_pay_q <= top_q[PAYLOAD_WIDTH-1:0];
							end
						end
						default: begin
							status_q  <= STATUS_OK;
							pop_key_q <= '0;
							pop_pay_q <= '0;
						end
					endcase
				end
			end
			ST_UP_CMP: begin
				if (up_move) pos_q <= parent;
			end
			ST_LAST_GET: begin
				ent_q <= rdata_a;
			end
			ST_DN_CMP: begin
				if (sel_r) begin
					pos_q <= right_w[ADDR_W-1:0];
				end else if (sel_l) begin
					pos_q <= left_w[ADDR_W-1:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tuser <= {top_valid, status_q};
					m_tdata <= {1'b0, tp_ext[PAYLOAD_PORT_W-1:0], tk_ext[KEY_PORT_W-1:0],
						cnt_ext[COUNT_PORT_W-1:0], pp_ext[PAYLOAD_PORT_W-1:0],
						pk_ext[KEY_PORT_W-1:0]};
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign pready = 1'b1;
	assign prdata = (reg_idx_t'(paddr[2]) == REG_LARGEST_FIRST) ?
		{{(APB_DATA_W-1){1'b0}}, largest_first_q} : '0;

endmodule

`default_nettype wire

// File: hw/rtl/bhpq_checker.sv
// Port-level checker for the binary heap priority queue, bound to the top level.
// Depends on bhpq_pkg and binary_heap_priority_queue_macros.svh.
`default_nettype none

`include "binary_heap_priority_queue_macros.svh"

module bhpq_checker
	import bhpq_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser
);

	logic empty_res, full_res, no_top;

	assign empty_res = m_tvalid && (status_t'(m_tuser[1:0]) == STATUS_EMPTY);
	assign full_res  = m_tvalid && (status_t'(m_tuser[1:0]) == STATUS_FULL);
	assign no_top    = m_tvalid && !m_tuser[2];

	`BHPQ_ASSERT_NOW(a_empty_pop, clk, arst_n, empty_res, m_tdata[63:0] == '0 && !m_tuser[2], "pop on empty heap reported an entry")
	`BHPQ_ASSERT_NOW(a_full_push, clk, arst_n, full_res, m_tuser[2] && m_tdata[63:0] == '0, "dropped push with no top or nonzero popped fields")
	`BHPQ_ASSERT_NOW(a_no_top, clk, arst_n, no_top, m_tdata[70:64] == '0 && m_tdata[134:71] == '0, "empty heap shows count or top entry")
	`BHPQ_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (.*);

`default_nettype wire

// File: verif/binary_heap_priority_queue_tb.sv
`timescale 1ns / 1ps
// Testbench for binary_heap_priority_queue: pushes, pops, clears and unused kinds
// over the stream port, order register over APB; results checked against a heap predictor.
// Depends on bhpq_pkg and the binary_heap_priority_queue RTL.

module binary_heap_priority_queue_tb;
	import bhpq_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		status_t     status;
		logic [31:0] popped_key;
		logic [31:0] popped_payload;
		logic [6:0]  entry_count;
		logic        top_valid;
		logic [31:0] top_key;
		logic [31:0] top_payload;
	} heap_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;    // key, payload
	logic [S_TUSER_W-1:0]  s_tuser = '0;    // kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;         // popped_key, popped_payload, entry_count,
	                                        // top_key, top_payload, pad
	logic [M_TUSER_W-1:0]  m_tuser;         // status, top_valid
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// heap predictor state
	logic [31:0] heap_key [BHPQ_CAPACITY];
	logic [31:0] heap_pay [BHPQ_CAPACITY];
	int          held_n = 0;
	logic        pop_largest = 1'b0;

	heap_result_t pending_q[$];
	int           mismatches = 0;
	bit           idle_on = 1'b1;
	int           quiet_cycles = 0;
	int           stall_left = 0;

	binary_heap_priority_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit ranks_above(int a, int b);
		if (pop_largest)
			return heap_key[a] > heap_key[b];
		return heap_key[a] < heap_key[b];
	endfunction

	function automatic void swap_entries(int a, int b);
		logic [31:0] k;
		logic [31:0] p;
		k = heap_key[a];
		p = heap_pay[a];
		heap_key[a] = heap_key[b];
		heap_pay[a] = heap_pay[b];
		heap_key[b] = k;
		heap_pay[b] = p;
	endfunction

	function automatic heap_result_t heap_apply(logic [1:0] op, logic [31:0] k, logic [31:0] p);
		heap_result_t r;
		int pos;
		int up;
		int lc;
		int rc;
		int best;
		bit done;
		r.status = STATUS_OK;
		r.popped_key = '0;
		r.popped_payload = '0;
		case (op)
			KIND_PUSH: begin
				if (held_n >= BHPQ_CAPACITY) begin
					r.status = STATUS_FULL;
				end else begin
					heap_key[held_n] = k;
					heap_pay[held_n] = p;
					pos = held_n;
					held_n++;
					done = 1'b0;
					while (pos > 0 && !done) begin
						up = (pos - 1) / 2;
						if (ranks_above(pos, up)) begin
							swap_entries(pos, up);
							pos = up;
						end else begin
							done = 1'b1;
						end
					end
				end
			end
			KIND_POP: begin
				if (held_n == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					r.popped_key = heap_key[0];
					r.popped_payload = heap_pay[0];
					held_n--;
					if (held_n > 0) begin
						heap_key[0] = heap_key[held_n];
						heap_pay[0] = heap_pay[held_n];
						pos = 0;
						done = 1'b0;
						while (!done) begin
							lc = 2 * pos + 1;
							rc = 2 * pos + 2;
							best = pos;
							if (lc < held_n && ranks_above(lc, best))
								best = lc;
							if (rc < held_n && ranks_above(rc, best))
								best = rc;
							if (best == pos) begin
								done = 1'b1;
							end else begin
								swap_entries(pos, best);
								pos = best;
							end
						end
					end
				end
			end
			KIND_CLEAR: held_n = 0;
			default: ;
		endcase
		r.entry_count = 7'(held_n);
		r.top_valid = held_n > 0;
		r.top_key = held_n > 0 ? heap_key[0] : '0;
		r.top_payload = held_n > 0 ? heap_pay[0] : '0;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic logic [31:0] rand_key();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2, 3, 4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// result side: random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(negedge clk) begin : result_check
		heap_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual tuser %0h tdata %0h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = pending_q.pop_front();
				check_field("status", 32'(want.status), 32'(m_tuser[1:0]));
				check_field("top_valid", 32'(want.top_valid), 32'(m_tuser[2]));
				check_field("popped_key", want.popped_key, m_tdata[31:0]);
				check_field("popped_payload", want.popped_payload, m_tdata[63:32]);
				check_field("entry_count", 32'(want.entry_count), 32'(m_tdata[70:64]));
				check_field("top_key", want.top_key, m_tdata[102:71]);
				check_field("top_payload", want.top_payload, m_tdata[134:103]);
			end
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("binary_heap_priority_queue: mismatch");
			$finish;
		end
	end

	// called and returning just after a rising edge
	task automatic send_item(logic [1:0] op, logic [31:0] k, logic [31:0] p);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {p, k};
		s_tuser <= op;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		pending_q.push_back(heap_apply(op, k, p));
		@(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_order(logic largest);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(4 * REG_LARGEST_FIRST);
		pwdata <= {31'b0, largest};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pop_largest = largest;
		@(posedge clk);
	endtask

	task automatic test_directed();
		write_order(1'b0);
		send_item(KIND_POP, $urandom, $urandom);
		send_item(KIND_PUSH, 32'd5, 32'hA);
		send_item(KIND_PUSH, 32'h0, 32'h0);
		send_item(KIND_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(KIND_PUSH, 32'd5, 32'hB);
		send_item(KIND_PUSH, 32'd5, 32'hC);
		send_item(KIND_UNUSED, $urandom, $urandom);
		repeat (6) send_item(KIND_POP, $urandom, $urandom);
		send_item(KIND_PUSH, 32'd7, $urandom);
		send_item(KIND_PUSH, 32'd3, $urandom);
		send_item(KIND_CLEAR, $urandom, $urandom);
		send_item(KIND_CLEAR, $urandom, $urandom);
		send_item(KIND_POP, $urandom, $urandom);
		write_order(1'b1);
		send_item(KIND_PUSH, 32'd1, 32'h1);
		send_item(KIND_PUSH, 32'hFFFF_FFFF, 32'h2);
		send_item(KIND_PUSH, 32'h0, 32'h3);
		send_item(KIND_PUSH, 32'd2, 32'h4);
		repeat (2) send_item(KIND_POP, $urandom, $urandom);
	endtask

	task automatic test_full_heap();
		send_item(KIND_CLEAR, $urandom, $urandom);
		repeat (BHPQ_CAPACITY + 2) send_item(KIND_PUSH, rand_key(), $urandom);
		repeat (BHPQ_CAPACITY + 1) send_item(KIND_POP, $urandom, $urandom);
	endtask

	// order flips while entries are held; the stored layout is not rebuilt
	task automatic test_order_switch();
		write_order(1'b0);
		repeat (20) send_item(KIND_PUSH, rand_key(), $urandom);
		write_order(1'b1);
		repeat (10) send_item(KIND_POP, $urandom, $urandom);
		repeat (5) send_item(KIND_PUSH, rand_key(), $urandom);
		write_order(1'b0);
		repeat (16) send_item(KIND_POP, $urandom, $urandom);
	endtask

	task automatic test_random_mix();
		int pick;
		int push_pct;
		for (int phase = 0; phase < 4; phase++) begin
			write_order(phase == 1 || phase == 2);
			idle_on = phase != 3;
			for (int n = 0; n < 175; n++) begin
				if (phase == 1 && n == 90)
					wait_drained();
				push_pct = held_n < 4 ? 70 : (held_n > 60 ? 30 : 52);
				pick = $urandom_range(0, 99);
				if (pick < 2)
					send_item(KIND_CLEAR, $urandom, $urandom);
				else if (pick < 4)
					send_item(KIND_UNUSED, $urandom, $urandom);
				else if (pick < 4 + push_pct)
					send_item(KIND_PUSH, rand_key(), $urandom);
				else
					send_item(KIND_POP, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_heap();
		test_order_switch();
		test_random_mix();
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("binary_heap_priority_queue: match");
		else
			$display("binary_heap_priority_queue: mismatch");
		$finish;
	end

endmodule
